// File: hdl/lrli_pkg.sv
// Package for the line rasteriser: field widths, register indexes,
// sequencer state type. No dependencies.
`default_nettype none
package lrli_pkg;
	localparam int MAX_DIM   = 64;
	localparam int COORD_W   = 6;
	localparam int DIM_W     = 7;
	localparam int IDX_W     = 12;
	localparam int COL_W     = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 7;
	localparam int PROD_W    = 2 * DIM_W;
	localparam int ERR_W     = 9;
	localparam int E2_W      = ERR_W + 1;

	// Register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATRIX_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_MAJOR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SERPENTINE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_CORNER = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STRIP_REV     = 3'd5;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd8;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_WALK
	} state_t;
endpackage
`default_nettype wire

// File: hdl/lrli_ifs.sv
// Channel interfaces of the line rasteriser: line input, LED point output,
// configuration write. Depends on lrli_pkg.
`default_nettype none
interface line_in_if;
	import lrli_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] start_x;
	logic [COORD_W-1:0] start_y;
	logic [COORD_W-1:0] end_x;
	logic [COORD_W-1:0] end_y;
	logic [COL_W-1:0]   red;
	logic [COL_W-1:0]   green;
	logic [COL_W-1:0]   blue;
	modport source (output valid, start_x, start_y, end_x, end_y, red, green, blue,
		input ready);
	modport sink (input valid, start_x, start_y, end_x, end_y, red, green, blue,
		output ready);
endinterface

interface led_out_if;
	import lrli_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] led_index;
	logic             in_bounds;
	logic [COL_W-1:0] out_red;
	logic [COL_W-1:0] out_green;
	logic [COL_W-1:0] out_blue;
	logic             last_point;
	modport source (output valid, led_index, in_bounds, out_red, out_green, out_blue,
		last_point, input ready);
	modport sink (input valid, led_index, in_bounds, out_red, out_green, out_blue,
		last_point, output ready);
endinterface

interface cfg_wr_if;
	import lrli_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/line_raster_to_led_index.sv
// Top level: Bresenham line walker with LED strip index mapping.
// Depends on lrli_pkg and the channel interfaces in lrli_ifs.sv.
//
// Usage
//  line_in : one beat holds two endpoints and a colour. Taken only when the
//            sequencer is idle; ready stays low until the last point of the
//            current line has been loaded into the output register.
//  led_out : one beat per point of the line, in walking order, last_point on
//            the final one. Points outside the matrix come out with
//            in_bounds low and index and colour zero.
//  cfg     : register writes, always ready. Write only while idle.
// Sequence
//  Accept -> a setup state (shared multiplier forms width*height-1), then
//  one point per cycle unless the receiver stalls, through the same
//  multiplier (row or column * span). A line has N points (N =
//  max(|dx|,|dy|)+1, at most 64); the sequencer returns to idle once the
//  last point is loaded, then takes the next line. The first point passes
//  the setup and walk states into the output register. A stalled receiver
//  freezes the walker: the output register holds its beat until it is taken.
// Reset
//  arst_n clears the sequencer to idle, empties the output register and
//  restores the registers to 8x8, row-major, top-left origin, no serpentine,
//  no strip reversal.
`default_nettype none
module line_raster_to_led_index (
	input  wire logic  clk,
	input  wire logic  arst_n,
	line_in_if.sink    line_in,
	led_out_if.source  led_out,
	cfg_wr_if.sink     cfg
);
	import lrli_pkg::*;

	// configuration registers
	logic [DIM_W-1:0] width_q, height_q;
	logic             col_major_q, serp_q, strip_rev_q;
	logic [1:0]       origin_q;

	// sequencer and walker
	state_t                    state_q, state_d;
	logic [COORD_W-1:0]        x_q, y_q, x1_q, y1_q;
	logic [COORD_W-1:0]        dx_q;
	logic signed [DIM_W-1:0]   dy_q;
	logic                      sx_q, sy_q;
	logic signed [ERR_W-1:0]   err_q;
	logic [COL_W-1:0]          red_q, green_q, blue_q;
	logic [IDX_W-1:0]          whm1_q;

	// output register
	logic             out_valid_q;
	logic [IDX_W-1:0] out_idx_q;
	logic             out_inb_q, out_last_q;
	logic [COL_W-1:0] out_r_q, out_g_q, out_b_q;

	// combinational
	logic [DIM_W-1:0]        w_sat, h_sat, px, py, line_no, span, other, pos;
	logic [DIM_W-1:0]        mul_a, mul_b;
	logic [PROD_W-1:0]       prod;
	logic [IDX_W-1:0]        lin_fwd, lin;
	logic                    inb, at_end, load, accept;
	logic signed [E2_W-1:0]  e2;
	logic                    step_x, step_y;
	logic signed [ERR_W-1:0] err_d;
	logic [COORD_W-1:0]      adx, ady;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= DIM_RESET;
			height_q    <= DIM_RESET;
			col_major_q <= 1'b0;
			serp_q      <= 1'b0;
			origin_q    <= 2'd0;
			strip_rev_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_MATRIX_WIDTH:  width_q     <= cfg.data;
				REG_MATRIX_HEIGHT: height_q    <= cfg.data;
				REG_COLUMN_MAJOR:  col_major_q <= cfg.data[0];
				REG_SERPENTINE:    serp_q      <= cfg.data[0];
				REG_ORIGIN_CORNER: origin_q    <= cfg.data[1:0];
				REG_STRIP_REV:     strip_rev_q <= cfg.data[0];
				default: ; // unused indexes ignored
			endcase
		end
	end

	// ---------------- handshakes ----------------
	assign line_in.ready = (state_q == ST_IDLE);
	assign accept        = line_in.valid && line_in.ready;
	// a point is formed only when the output register is free or being emptied
	assign load = (state_q == ST_WALK) && (!out_valid_q || led_out.ready);

	// ---------------- point mapping ----------------
	always_comb begin
		w_sat = (width_q > DIM_W'(MAX_DIM))  ? DIM_W'(MAX_DIM) : width_q;
		h_sat = (height_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : height_q;
		inb   = ({1'b0, x_q} < w_sat) && ({1'b0, y_q} < h_sat);
		// origin flips: bit 0 mirrors x, bit 1 mirrors y
		px = origin_q[0] ? (w_sat - 7'd1 - {1'b0, x_q}) : {1'b0, x_q};
		py = origin_q[1] ? (h_sat - 7'd1 - {1'b0, y_q}) : {1'b0, y_q};
		line_no = col_major_q ? px : py;
		span    = col_major_q ? h_sat : w_sat;
		other   = col_major_q ? py : px;
		pos     = (serp_q && line_no[0]) ? (span - 7'd1 - other) : other;
		// the one multiplier: width*height at setup, line*span while walking
		mul_a = (state_q == ST_SETUP) ? w_sat : line_no;
		mul_b = (state_q == ST_SETUP) ? h_sat : span;
		prod  = PROD_W'(mul_a) * PROD_W'(mul_b);
		lin_fwd = prod[IDX_W-1:0] + IDX_W'(pos);
		lin     = strip_rev_q ? (whm1_q - lin_fwd) : lin_fwd;
		at_end  = (x_q == x1_q) && (y_q == y1_q);
	end

	// ---------------- Bresenham step ----------------
	always_comb begin
		e2     = {err_q, 1'b0};
		step_x = e2 >= E2_W'(dy_q);
		step_y = e2 <= $signed({{(E2_W-COORD_W){1'b0}}, dx_q});
		err_d  = err_q
			+ (step_x ? ERR_W'(dy_q) : ERR_W'(0))
			+ (step_y ? $signed({{(ERR_W-COORD_W){1'b0}}, dx_q}) : ERR_W'(0));
		adx = (line_in.end_x > line_in.start_x) ? (line_in.end_x - line_in.start_x)
			: (line_in.start_x - line_in.end_x);
		ady = (line_in.end_y > line_in.start_y) ? (line_in.end_y - line_in.start_y)
			: (line_in.start_y - line_in.end_y);
	end

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_d = ST_SETUP;
			ST_SETUP: state_d = ST_WALK;
			ST_WALK:  if (load && at_end) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// walker datapath; no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= line_in.start_x;
			y_q     <= line_in.start_y;
			x1_q    <= line_in.end_x;
			y1_q    <= line_in.end_y;
			dx_q    <= adx;
			dy_q    <= -$signed({1'b0, ady});
			sx_q    <= line_in.start_x < line_in.end_x;
			sy_q    <= line_in.start_y < line_in.end_y;
			err_q   <= $signed({{(ERR_W-COORD_W){1'b0}}, adx})
				- $signed({{(ERR_W-COORD_W){1'b0}}, ady});
			red_q   <= line_in.red;
			green_q <= line_in.green;
			blue_q  <= line_in.blue;
		end
		if (state_q == ST_SETUP) begin
			whm1_q <= prod[IDX_W-1:0] - IDX_W'(1);
		end
		if (load && !at_end) begin
			err_q <= err_d;
			if (step_x) x_q <= sx_q ? (x_q + 6'd1) : (x_q - 6'd1);
			if (step_y) y_q <= sy_q ? (y_q + 6'd1) : (y_q - 6'd1);
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (led_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_idx_q  <= inb ? lin : '0;
			out_inb_q  <= inb;
			out_r_q    <= inb ? red_q   : '0;
			out_g_q    <= inb ? green_q : '0;
			out_b_q    <= inb ? blue_q  : '0;
			out_last_q <= at_end;
		end
	end

	assign led_out.valid      = out_valid_q;
	assign led_out.led_index  = out_idx_q;
	assign led_out.in_bounds  = out_inb_q;
	assign led_out.out_red    = out_r_q;
	assign led_out.out_green  = out_g_q;
	assign led_out.out_blue   = out_b_q;
	assign led_out.last_point = out_last_q;

	// ---------------- assertions ----------------
	a_accept_setup: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_SETUP)
		else $error("line beat taken but sequencer not in setup");

	a_oob_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_inb_q) |-> (out_idx_q == '0 && out_r_q == '0
			&& out_g_q == '0 && out_b_q == '0))
		else $error("out-of-bounds beat carries non-zero payload");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && at_end) |=> (state_q == ST_IDLE && out_last_q && out_valid_q))
		else $error("final point did not end the walk");

	a_walk_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && out_valid_q && !led_out.ready) |=> $stable(x_q)
			&& $stable(y_q))
		else $error("walker stepped while output stalled");
endmodule
`default_nettype wire

// File: tb/sv/line_raster_to_led_index_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for line_raster_to_led_index: line beats in, LED point beats out.
// Depends on lrli_pkg, the channel interfaces in lrli_ifs.sv and the rasteriser RTL.
module line_raster_to_led_index_tb;
	import lrli_pkg::*;

	// Origin corner codes as held in the corner register
	localparam logic [1:0] CORNER_TOP_LEFT     = 2'd0;
	localparam logic [1:0] CORNER_TOP_RIGHT    = 2'd1;
	localparam logic [1:0] CORNER_BOTTOM_LEFT  = 2'd2;
	localparam logic [1:0] CORNER_BOTTOM_RIGHT = 2'd3;

	// Indexes past the register list; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	localparam int MAX_POINTS   = 64;      // longest line on the largest matrix
	localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
	localparam int DRAIN_CYCLES = 70;      // outlasts the longest line
	localparam int RUN_LIMIT_NS = 5000000; // overall simulation limit

	typedef struct packed {
		logic [COORD_W-1:0] x0, y0, x1, y1;
		logic [COL_W-1:0]   red, green, blue;
	} line_t;

	typedef struct packed {
		logic [IDX_W-1:0] led_index;
		logic             in_bounds;
		logic [COL_W-1:0] red, green, blue;
		logic             last_point;
	} point_t;

	typedef struct {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             column_major;
		logic             serpentine;
		logic [1:0]       corner;
		logic             strip_rev;
	} layout_t;

	logic clk;
	logic arst_n;

	line_in_if line_in ();
	led_out_if led_out ();
	cfg_wr_if  cfg ();

	line_raster_to_led_index dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.line_in (line_in),
		.led_out (led_out),
		.cfg     (cfg)
	);

	// Mirror of the register file, as the block should hold it
	layout_t layout;

	line_t  pending_lines[$];   // beats waiting for the driver
	point_t expected_points[$]; // predicted LED points, oldest first
	point_t point_due;

	int  lines_queued;
	int  lines_taken;
	int  fail_count;
	int  send_idle_pct;
	int  recv_stall_pct;
	int  hold_req;
	int  hold_seen;
	int  hold_left;
	bit  line_fired;   // line beat taken at the last rising edge
	line_t drv_line;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Overall limit: far above the slowest legal run
	initial begin
		#(RUN_LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("%0t ns  mismatch: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
	endtask

	// Strip position of (x,y) under the current layout; 0 when off the matrix.
	// Dimensions above MAX_DIM saturate; a zero dimension leaves nothing in bounds.
	function automatic bit led_position(input int x, input int y,
		output logic [IDX_W-1:0] idx);
		int w, h, px, py, row, pos, lin;
		w = (layout.width > MAX_DIM) ? MAX_DIM : int'(layout.width);
		h = (layout.height > MAX_DIM) ? MAX_DIM : int'(layout.height);
		idx = '0;
		if (x >= w || y >= h)
			return 1'b0;
		px = (layout.corner == CORNER_TOP_RIGHT || layout.corner == CORNER_BOTTOM_RIGHT)
			? w - 1 - x : x;
		py = (layout.corner == CORNER_BOTTOM_LEFT || layout.corner == CORNER_BOTTOM_RIGHT)
			? h - 1 - y : y;
		if (!layout.column_major) begin
			row = py;
			pos = (layout.serpentine && row[0]) ? w - 1 - px : px;
			lin = row * w + pos;
		end else begin
			row = px;
			pos = (layout.serpentine && row[0]) ? h - 1 - py : py;
			lin = row * h + pos;
		end
		if (layout.strip_rev)
			lin = w * h - 1 - lin;
		idx = lin[IDX_W-1:0];
		return 1'b1;
	endfunction

	// Bresenham walk from the first endpoint to the second, one point each step
	task automatic predict_points(input line_t ln);
		int x, y, xe, ye, dx, dy, sx, sy, err, e2;
		point_t p;
		logic [IDX_W-1:0] idx;
		bit inb;
		x = ln.x0;
		y = ln.y0;
		xe = ln.x1;
		ye = ln.y1;
		dx = (xe > x) ? xe - x : x - xe;
		dy = (ye > y) ? y - ye : ye - y;
		sx = (x < xe) ? 1 : -1;
		sy = (y < ye) ? 1 : -1;
		err = dx + dy;
		for (int n = 0; n < MAX_POINTS; n++) begin
			inb = led_position(x, y, idx);
			p.led_index  = inb ? idx : '0;
			p.in_bounds  = inb;
			p.red        = inb ? ln.red : '0;
			p.green      = inb ? ln.green : '0;
			p.blue       = inb ? ln.blue : '0;
			p.last_point = (x == xe && y == ye);
			expected_points.push_back(p);
			if (p.last_point)
				break;
			e2 = err + err;
			if (e2 >= dy) begin
				err += dy;
				x += sx;
			end
			if (e2 <= dx) begin
				err += dx;
				y += sy;
			end
		end
	endtask

	// Monitor: sample both channels at the rising edge. A taken line beat is
	// predicted straight away; each point beat is checked against the oldest
	// prediction.
	always @(posedge clk) begin
		line_fired <= arst_n && line_in.valid && line_in.ready;
		if (arst_n && line_in.valid && line_in.ready) begin
			predict_points('{line_in.start_x, line_in.start_y, line_in.end_x,
				line_in.end_y, line_in.red, line_in.green, line_in.blue});
			lines_taken++;
		end
		if (arst_n && led_out.valid && led_out.ready) begin
			if (expected_points.size() == 0) begin
				report_mismatch($sformatf("point beat with nothing expected, index %0d",
					led_out.led_index));
			end else begin
				point_due = expected_points.pop_front();
				check_field("led_index", led_out.led_index, point_due.led_index);
				check_field("in_bounds", led_out.in_bounds, point_due.in_bounds);
				check_field("out_red", led_out.out_red, point_due.red);
				check_field("out_green", led_out.out_green, point_due.green);
				check_field("out_blue", led_out.out_blue, point_due.blue);
				check_field("last_point", led_out.last_point, point_due.last_point);
			end
		end
	end

	// Line driver: at the falling edge, keep an untaken beat steady; otherwise
	// offer the next pending line unless this cycle is picked as a gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			line_in.valid <= 1'b0;
		end else if (!line_in.valid || line_fired) begin
			if (pending_lines.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_line = pending_lines.pop_front();
				line_in.valid   <= 1'b1;
				line_in.start_x <= drv_line.x0;
				line_in.start_y <= drv_line.y0;
				line_in.end_x   <= drv_line.x1;
				line_in.end_y   <= drv_line.y1;
				line_in.red     <= drv_line.red;
				line_in.green   <= drv_line.green;
				line_in.blue    <= drv_line.blue;
			end else begin
				line_in.valid <= 1'b0;
			end
		end
	end

	// Point receiver: random stalls, plus a long hold-off on request so the
	// output register fills and the line input backs up.
	always @(negedge clk) begin
		if (!arst_n) begin
			led_out.ready <= 1'b0;
		end else if (hold_left != 0) begin
			led_out.ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			led_out.ready <= 1'b0;
		end else begin
			led_out.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// One register write; entered at a falling edge, leaves at one
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DAT_W-1:0] val);
		cfg.valid = 1'b1;
		cfg.index = idx;
		cfg.data  = val;
		do @(posedge clk); while (!cfg.ready);
		case (idx)
			REG_MATRIX_WIDTH:  layout.width        = val;
			REG_MATRIX_HEIGHT: layout.height       = val;
			REG_COLUMN_MAJOR:  layout.column_major = val[0];
			REG_SERPENTINE:    layout.serpentine   = val[0];
			REG_ORIGIN_CORNER: layout.corner       = val[1:0];
			REG_STRIP_REV:     layout.strip_rev    = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg.valid = 1'b0;
	endtask

	// Full layout write; junk in the unused upper data bits must be dropped
	task automatic set_layout(input int w, input int h, input bit col_major,
		input bit serp, input logic [1:0] corner, input bit rev);
		write_reg(REG_MATRIX_WIDTH, w[DIM_W-1:0]);
		write_reg(REG_MATRIX_HEIGHT, h[DIM_W-1:0]);
		write_reg(REG_COLUMN_MAJOR, {6'($urandom_range(63)), col_major});
		write_reg(REG_SERPENTINE, {6'($urandom_range(63)), serp});
		write_reg(REG_ORIGIN_CORNER, {5'($urandom_range(31)), corner});
		write_reg(REG_STRIP_REV, {6'($urandom_range(63)), rev});
	endtask

	// Idle once every queued line is taken and every point has come out
	task automatic wait_idle();
		do @(negedge clk);
		while (lines_taken != lines_queued || expected_points.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic queue_line(input int x0, input int y0, input int x1, input int y1,
		input int r, input int g, input int b);
		pending_lines.push_back('{x0[COORD_W-1:0], y0[COORD_W-1:0], x1[COORD_W-1:0],
			y1[COORD_W-1:0], r[COL_W-1:0], g[COL_W-1:0], b[COL_W-1:0]});
		lines_queued++;
	endtask

	// Mostly near the matrix (edge included), a quarter over the whole field
	function automatic int pick_coord(input int span);
		return ($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(span);
	endfunction

	task automatic run_lines(input int count, input int send_pct, input int recv_pct,
		input bit hold);
		int xs, ys;
		xs = (layout.width > 62) ? 63 : layout.width + 1;
		ys = (layout.height > 62) ? 63 : layout.height + 1;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		repeat (count)
			queue_line(pick_coord(xs), pick_coord(ys), pick_coord(xs), pick_coord(ys),
				$urandom_range(255), $urandom_range(255), $urandom_range(255));
		if (hold)
			hold_req++;
		wait_idle();
	endtask

	initial begin
		arst_n = 1'b0;
		line_in.valid   = 1'b0;
		line_in.start_x = '0;
		line_in.start_y = '0;
		line_in.end_x   = '0;
		line_in.end_y   = '0;
		line_in.red     = '0;
		line_in.green   = '0;
		line_in.blue    = '0;
		led_out.ready   = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data  = '0;
		layout = '{DIM_RESET, DIM_RESET, 1'b0, 1'b0, CORNER_TOP_LEFT, 1'b0};
		lines_queued = 0;
		lines_taken = 0;
		fail_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 0;
		hold_seen = 0;
		hold_left = 0;
		line_fired = 1'b0;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed lines on the reset 8x8 layout: single points, both
		// directions of flat and upright lines, diagonals, the longest lines,
		// shallow and steep slopes, and lines running off the matrix.
		queue_line(0, 0, 0, 0, 255, 255, 255);
		queue_line(63, 63, 63, 63, 0, 0, 0);
		queue_line(0, 0, 7, 7, 1, 2, 3);
		queue_line(7, 0, 0, 7, 128, 64, 32);
		queue_line(0, 3, 7, 3, 255, 0, 255);
		queue_line(7, 3, 0, 3, 0, 255, 0);
		queue_line(2, 0, 2, 7, 17, 34, 51);
		queue_line(2, 7, 2, 0, 200, 100, 50);
		queue_line(0, 0, 63, 63, 255, 255, 255);
		queue_line(63, 0, 0, 63, 85, 170, 85);
		queue_line(0, 0, 63, 5, 9, 8, 7);
		queue_line(5, 63, 0, 0, 7, 8, 9);
		queue_line(1, 2, 6, 5, 90, 91, 92);
		queue_line(6, 1, 2, 7, 93, 94, 95);
		queue_line(0, 63, 63, 0, 170, 85, 170);
		queue_line(63, 63, 0, 0, 165, 90, 60);
		wait_idle();

		// Largest matrix, long lines; the receiver holds off once mid-phase
		set_layout(64, 64, 1'b0, 1'b0, CORNER_TOP_LEFT, 1'b0);
		run_lines(35, 0, 0, 1'b1);
		set_layout(64, 64, 1'b1, 1'b1, CORNER_TOP_RIGHT, 1'b1);
		run_lines(35, 47, 0, 1'b0);
		set_layout(16, 8, 1'b0, 1'b1, CORNER_BOTTOM_LEFT, 1'b0);
		run_lines(35, 0, 47, 1'b0);
		set_layout(8, 16, 1'b1, 1'b0, CORNER_BOTTOM_RIGHT, 1'b1);
		run_lines(35, 8, 8, 1'b0);
		set_layout(1, 1, 1'b0, 1'b0, CORNER_TOP_LEFT, 1'b0);
		run_lines(30, 0, 0, 1'b0);
		// zero width: nothing lands on the matrix
		set_layout(0, 64, 1'b1, 1'b1, CORNER_BOTTOM_RIGHT, 1'b1);
		run_lines(20, 47, 0, 1'b0);
		// over-range dimensions saturate; spare indexes must not disturb them
		set_layout(127, 100, 1'b1, 1'b1, CORNER_BOTTOM_RIGHT, 1'b0);
		write_reg(REG_SPARE_LO, 7'h7F);
		write_reg(REG_SPARE_HI, 7'h00);
		run_lines(35, 0, 47, 1'b0);
		set_layout(64, 1, 1'b0, 1'b1, CORNER_TOP_RIGHT, 1'b1);
		run_lines(30, 8, 8, 1'b0);
		set_layout(1, 64, 1'b1, 1'b1, CORNER_BOTTOM_LEFT, 1'b1);
		run_lines(30, 0, 0, 1'b0);
		set_layout(33, 47, 1'b0, 1'b1, CORNER_BOTTOM_RIGHT, 1'b1);
		run_lines(35, 0, 47, 1'b0);

		// Let any stray beat show itself before the verdict
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
